FILE: sv/mpb_pkg.sv
// ----------------------------------------------------------------------------
// mpb_pkg
// Shared widths, codes and types for the max pooling / argmax backprop core.
// ----------------------------------------------------------------------------
`default_nettype none

package mpb_pkg;

  localparam int unsigned MAX_ELEMENTS = 4096;
  localparam int unsigned ADDR_W       = $clog2(MAX_ELEMENTS);
  localparam int unsigned LIMIT_W      = ADDR_W + 1;
  localparam int unsigned VALUE_W      = 16;
  localparam int unsigned GRAD_W       = 20;
  localparam int unsigned MAX_WINDOW   = 8;
  localparam int unsigned DIM_W        = 7;
  localparam int unsigned CNT_W        = 6;
  localparam int unsigned WIN_W        = 4;
  localparam int unsigned SIZE_W       = 19;
  localparam int unsigned CFG_IDX_W    = 3;
  localparam int unsigned CFG_DATA_W   = 8;

  typedef enum logic [1:0] {
    ACT_FEATURE = 2'd0,
    ACT_GRAD    = 2'd1,
    ACT_READ    = 2'd2
  } action_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_CHAN   = 3'd0,
    CFG_HEIGHT = 3'd1,
    CFG_WIDTH  = 3'd2,
    CFG_WIN    = 3'd3,
    CFG_STEP   = 3'd4
  } cfg_index_e;

  localparam logic KIND_POOL  = 1'b0;
  localparam logic KIND_READ  = 1'b1;
  localparam logic STAT_OK    = 1'b0;
  localparam logic STAT_RANGE = 1'b1;

  typedef struct packed {
    logic [DIM_W-1:0] chan;
    logic [DIM_W-1:0] height;
    logic [DIM_W-1:0] width;
    logic [WIN_W-1:0] win;
    logic [WIN_W-1:0] step;
  } mpb_cfg_t;

  typedef struct packed {
    logic                busy;
    logic [SIZE_W-1:0]   sample_size;
    logic [LIMIT_W-1:0]  out_limit;
    logic [ADDR_W-1:0]   scan_back;
  } mpb_geom_t;

endpackage

`default_nettype wire

FILE: sv/mpb_geom.sv
// ----------------------------------------------------------------------------
// mpb_geom
// Configuration registers and derived pooling geometry (output sizes, sample
// size, gradient wrap limit, window scan offset), recomputed after reset and
// after every register write.
// ----------------------------------------------------------------------------
`default_nettype none

module mpb_geom
  import mpb_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_valid_i,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_wdata_i,
  output mpb_cfg_t              cfg_o,
  output mpb_geom_t             geom_o,
  output logic                  cfg_clr_o
);

  localparam logic [2:0] DM_IDLE  = 3'd0;
  localparam logic [2:0] DM_START = 3'd1;
  localparam logic [2:0] DM_ITER  = 3'd2;
  localparam logic [2:0] DM_MUL1  = 3'd3;
  localparam logic [2:0] DM_MUL2  = 3'd4;

  localparam int unsigned WIN_MAX = (MAX_WINDOW < 8) ? MAX_WINDOW : 8;

  function automatic logic [CFG_DATA_W-1:0] clamp(input logic [CFG_DATA_W-1:0] v,
                                                  input logic [CFG_DATA_W-1:0] lo,
                                                  input logic [CFG_DATA_W-1:0] hi);
    logic [CFG_DATA_W-1:0] r;
    r = v;
    if (v < lo) r = lo;
    else if (v > hi) r = hi;
    return r;
  endfunction

  mpb_cfg_t             cfg_q;
  logic [2:0]           dm_q, dm_d;
  logic                 cfg_we;
  logic                 h_go, w_go;
  logic [DIM_W-1:0]     hpos_q, wpos_q, hcnt_q, wcnt_q;
  logic [LIMIT_W-1:0]   hw_q, howo_q, limit_q;
  logic [ADDR_W-1:0]    back_q;
  logic [SIZE_W-1:0]    size_q, tot;

  assign cfg_we    = cfg_valid_i && (cfg_index_i <= CFG_STEP);
  assign cfg_clr_o = cfg_we;
  assign cfg_o     = cfg_q;

  assign h_go = hpos_q < cfg_q.height;
  assign w_go = wpos_q < cfg_q.width;
  assign tot  = SIZE_W'(cfg_q.chan) * SIZE_W'(howo_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.chan   <= DIM_W'(1);
      cfg_q.height <= DIM_W'(28);
      cfg_q.width  <= DIM_W'(28);
      cfg_q.win    <= WIN_W'(2);
      cfg_q.step   <= WIN_W'(2);
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        CFG_CHAN:   cfg_q.chan   <= DIM_W'(clamp(cfg_wdata_i, CFG_DATA_W'(1), CFG_DATA_W'(64)));
        CFG_HEIGHT: cfg_q.height <= DIM_W'(clamp(cfg_wdata_i, CFG_DATA_W'(1), CFG_DATA_W'(64)));
        CFG_WIDTH:  cfg_q.width  <= DIM_W'(clamp(cfg_wdata_i, CFG_DATA_W'(1), CFG_DATA_W'(64)));
        CFG_WIN:    cfg_q.win    <= WIN_W'(clamp(cfg_wdata_i, CFG_DATA_W'(1),
                                                 CFG_DATA_W'(WIN_MAX)));
        CFG_STEP:   cfg_q.step   <= WIN_W'(clamp(cfg_wdata_i, CFG_DATA_W'(1), CFG_DATA_W'(8)));
        default: ;
      endcase
    end
  end

  always_comb begin
    dm_d = dm_q;
    unique case (dm_q)
      DM_IDLE:  dm_d = DM_IDLE;
      DM_START: dm_d = DM_ITER;
      DM_ITER:  if (!h_go && !w_go) dm_d = DM_MUL1;
      DM_MUL1:  dm_d = DM_MUL2;
      DM_MUL2:  dm_d = DM_IDLE;
      default:  dm_d = DM_START;
    endcase
    if (cfg_we) dm_d = DM_START;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dm_q <= DM_START;
    end else begin
      dm_q <= dm_d;
    end
  end

  // count window positions per dimension: start at win-1, step until past the edge
  always_ff @(posedge clk_i) begin
    unique case (dm_q)
      DM_START: begin
        hpos_q <= DIM_W'(cfg_q.win) - DIM_W'(1);
        wpos_q <= DIM_W'(cfg_q.win) - DIM_W'(1);
        hcnt_q <= '0;
        wcnt_q <= '0;
      end
      DM_ITER: begin
        if (h_go) begin
          hpos_q <= hpos_q + DIM_W'(cfg_q.step);
          hcnt_q <= hcnt_q + DIM_W'(1);
        end
        if (w_go) begin
          wpos_q <= wpos_q + DIM_W'(cfg_q.step);
          wcnt_q <= wcnt_q + DIM_W'(1);
        end
      end
      DM_MUL1: begin
        hw_q   <= LIMIT_W'(cfg_q.height) * LIMIT_W'(cfg_q.width);
        howo_q <= LIMIT_W'(hcnt_q) * LIMIT_W'(wcnt_q);
        back_q <= ADDR_W'(cfg_q.win - WIN_W'(1)) * (ADDR_W'(cfg_q.width) + ADDR_W'(1));
      end
      DM_MUL2: begin
        size_q  <= SIZE_W'(cfg_q.chan) * SIZE_W'(hw_q);
        limit_q <= (tot > SIZE_W'(MAX_ELEMENTS)) ? LIMIT_W'(MAX_ELEMENTS) : LIMIT_W'(tot);
      end
      default: ;
    endcase
  end

  assign geom_o.busy        = (dm_q != DM_IDLE);
  assign geom_o.sample_size = size_q;
  assign geom_o.out_limit   = limit_q;
  assign geom_o.scan_back   = back_q;

endmodule

`default_nettype wire

FILE: sv/max_pool_2d_with_argmax_backprop_core.sv
// ----------------------------------------------------------------------------
// max_pool_2d_with_argmax_backprop_core
// 2-D max pooling with argmax mask and saturating gradient routing.
// ----------------------------------------------------------------------------
// Feature beats are written into a frame memory at consecutive flat indices;
// a beat that completes a pooling window starts a scan of that window through
// the single frame read port, one entry per cycle; other feature beats start
// no scan. Gradient beats read the winner memory, then do a read-modify-write
// of the gradient memory; gradient readouts read the gradient memory unless
// the index is out of range. After reset the input stays stalled while the
// gradient memory is cleared; after a register write it stalls while the
// geometry is recomputed. A finished result waits in an output register, so
// the next beat is taken while the previous result has not yet been consumed.
// ----------------------------------------------------------------------------
`default_nettype none

module max_pool_2d_with_argmax_backprop_core
  import mpb_pkg::*;
(
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      in_valid_i,
  output logic                      in_ready_o,
  input  logic [1:0]                action_i,
  input  logic signed [VALUE_W-1:0] sample_value_i,
  input  logic [ADDR_W-1:0]         read_index_i,
  output logic                      out_valid_o,
  input  logic                      out_ready_i,
  output logic                      kind_o,
  output logic signed [GRAD_W-1:0]  result_value_o,
  output logic [ADDR_W-1:0]         winner_index_o,
  output logic [ADDR_W-1:0]         output_position_o,
  output logic                      status_o,
  input  logic                      cfg_valid_i,
  output logic                      cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]      cfg_index_i,
  input  logic [CFG_DATA_W-1:0]     cfg_wdata_i
);

  localparam logic [2:0] S_CLEAR     = 3'd0;
  localparam logic [2:0] S_IDLE      = 3'd1;
  localparam logic [2:0] S_SCAN      = 3'd2;
  localparam logic [2:0] S_SCAN_LAST = 3'd3;
  localparam logic [2:0] S_EMIT      = 3'd4;
  localparam logic [2:0] S_GRD_W     = 3'd5;
  localparam logic [2:0] S_GRD_A     = 3'd6;
  localparam logic [2:0] S_RD_WAIT   = 3'd7;

  localparam logic [GRAD_W-1:0] GRAD_MAX = {1'b0, {(GRAD_W-1){1'b1}}};
  localparam logic [GRAD_W-1:0] GRAD_MIN = ~GRAD_MAX;

  mpb_cfg_t  cfg;
  mpb_geom_t geom;
  logic      cfg_clr;

  logic [2:0]             state_q, state_d;
  logic                   in_fire, out_free;

  logic [CNT_W-1:0]       col_q, row_q, ch_q;
  logic [DIM_W-1:0]       rk_q, ck_q;
  logic [ADDR_W-1:0]      waddr_q, pos_q, gc_q, clr_q;
  logic                   col_last, row_last, ch_last, col_hit, row_hit, win_hit;
  logic [WIN_W-2:0]       win_m1, pi_q, pj_q;
  logic                   pi_last, pj_last;

  logic [ADDR_W-1:0]      gc_eff, gc_next;
  logic [LIMIT_W-1:0]     gc_inc;
  logic                   range_err;

  logic [ADDR_W-1:0]      row_base_q, iss_idx_q, top_idx_q;
  logic                   iss_q, first_q;
  logic signed [VALUE_W-1:0] best_q, grad_val_q;

  logic                   res_kind_q, res_status_q;
  logic signed [GRAD_W-1:0] res_value_q, pool_value;
  logic [ADDR_W-1:0]      res_pos_q, grad_idx_q;

  logic signed [GRAD_W:0] sum;
  logic [GRAD_W-1:0]      sat_sum;

  logic                   out_valid_q, out_kind_q, out_status_q;
  logic signed [GRAD_W-1:0] out_value_q;
  logic [ADDR_W-1:0]      out_widx_q, out_pos_q;

  logic signed [VALUE_W-1:0] frame_mem [MAX_ELEMENTS];
  logic [ADDR_W-1:0]         winner_mem [MAX_ELEMENTS];
  logic signed [GRAD_W-1:0]  grad_mem [MAX_ELEMENTS];
  logic signed [VALUE_W-1:0] frame_rdata_q;
  logic [ADDR_W-1:0]         winner_rdata_q;
  logic signed [GRAD_W-1:0]  grad_rdata_q;

  logic                   frame_we, frame_re, winner_we, winner_re, grad_we, grad_re;
  logic [ADDR_W-1:0]      frame_raddr, grad_raddr, grad_waddr;
  logic [GRAD_W-1:0]      grad_wdata;

  mpb_geom u_geom (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_index_i (cfg_index_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cfg_o       (cfg),
    .geom_o      (geom),
    .cfg_clr_o   (cfg_clr)
  );

  assign cfg_ready_o = 1'b1;
  assign in_ready_o  = (state_q == S_IDLE) && !geom.busy;
  assign in_fire     = in_valid_i && in_ready_o;
  assign out_free    = !out_valid_q || out_ready_i;

  // window completion tracking
  assign win_m1   = (WIN_W-1)'(cfg.win - WIN_W'(1));
  assign col_last = (DIM_W'(col_q) + DIM_W'(1)) >= cfg.width;
  assign row_last = (DIM_W'(row_q) + DIM_W'(1)) >= cfg.height;
  assign ch_last  = (DIM_W'(ch_q) + DIM_W'(1)) >= cfg.chan;
  assign col_hit  = DIM_W'(col_q) == (DIM_W'(win_m1) + ck_q);
  assign row_hit  = DIM_W'(row_q) == (DIM_W'(win_m1) + rk_q);
  assign win_hit  = col_hit && row_hit;
  assign pj_last  = (pj_q == win_m1);
  assign pi_last  = (pi_q == win_m1);

  assign gc_eff    = (LIMIT_W'(gc_q) >= geom.out_limit) ? '0 : gc_q;
  assign gc_inc    = LIMIT_W'(gc_eff) + LIMIT_W'(1);
  assign gc_next   = (gc_inc >= geom.out_limit) ? '0 : gc_inc[ADDR_W-1:0];
  assign range_err = SIZE_W'(read_index_i) >= geom.sample_size;

  assign sum        = (GRAD_W+1)'(grad_rdata_q) + (GRAD_W+1)'(grad_val_q);
  assign sat_sum    = (sum[GRAD_W] != sum[GRAD_W-1]) ? (sum[GRAD_W] ? GRAD_MIN : GRAD_MAX)
                                                     : sum[GRAD_W-1:0];
  assign pool_value = GRAD_W'(best_q);

  always_comb begin
    state_d     = state_q;
    frame_we    = 1'b0;
    frame_re    = 1'b0;
    winner_we   = 1'b0;
    winner_re   = 1'b0;
    grad_we     = 1'b0;
    grad_re     = 1'b0;
    frame_raddr = row_base_q + ADDR_W'(pj_q);
    grad_raddr  = read_index_i;
    grad_waddr  = grad_idx_q;
    grad_wdata  = '0;
    unique case (state_q)
      S_CLEAR: begin
        grad_we    = 1'b1;
        grad_waddr = clr_q;
        if (clr_q == {ADDR_W{1'b1}}) state_d = S_IDLE;
      end
      S_IDLE: begin
        if (in_fire) begin
          unique case (action_i)
            ACT_FEATURE: begin
              frame_we = 1'b1;
              if (win_hit) state_d = S_SCAN;
            end
            ACT_GRAD: begin
              if (geom.out_limit != '0) begin
                winner_re = 1'b1;
                state_d   = S_GRD_W;
              end
            end
            ACT_READ: begin
              if (range_err) begin
                state_d = S_EMIT;
              end else begin
                grad_re = 1'b1;
                state_d = S_RD_WAIT;
              end
            end
            default: ;
          endcase
        end
      end
      S_SCAN: begin
        frame_re = 1'b1;
        if (pj_last && pi_last) state_d = S_SCAN_LAST;
      end
      S_SCAN_LAST: state_d = S_EMIT;
      S_EMIT: begin
        if (out_free) begin
          winner_we = (res_kind_q == KIND_POOL);
          state_d   = S_IDLE;
        end
      end
      S_GRD_W: begin
        grad_re    = 1'b1;
        grad_raddr = winner_rdata_q;
        state_d    = S_GRD_A;
      end
      S_GRD_A: begin
        grad_we    = 1'b1;
        grad_wdata = sat_sum;
        state_d    = S_IDLE;
      end
      S_RD_WAIT: begin
        grad_we = 1'b1;
        state_d = S_EMIT;
      end
      default: state_d = S_IDLE;
    endcase
  end

  // memories
  always_ff @(posedge clk_i) begin
    if (frame_we) frame_mem[waddr_q] <= sample_value_i;
    if (frame_re) frame_rdata_q <= frame_mem[frame_raddr];
  end

  always_ff @(posedge clk_i) begin
    if (winner_we) winner_mem[res_pos_q] <= top_idx_q;
    if (winner_re) winner_rdata_q <= winner_mem[gc_eff];
  end

  always_ff @(posedge clk_i) begin
    if (grad_we) grad_mem[grad_waddr] <= grad_wdata;
    if (grad_re) grad_rdata_q <= grad_mem[grad_raddr];
  end

  // control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLEAR;
      clr_q       <= '0;
      iss_q       <= 1'b0;
      out_valid_q <= 1'b0;
      col_q       <= '0;
      row_q       <= '0;
      ch_q        <= '0;
      ck_q        <= '0;
      rk_q        <= '0;
      waddr_q     <= '0;
      pos_q       <= '0;
      gc_q        <= '0;
    end else begin
      state_q <= state_d;
      iss_q   <= (state_q == S_SCAN);
      if (state_q == S_CLEAR) clr_q <= clr_q + ADDR_W'(1);
      if (state_q == S_EMIT && out_free) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      if (cfg_clr) begin
        col_q   <= '0;
        row_q   <= '0;
        ch_q    <= '0;
        ck_q    <= '0;
        rk_q    <= '0;
        waddr_q <= '0;
        pos_q   <= '0;
        gc_q    <= '0;
      end else if (in_fire) begin
        unique case (action_i)
          ACT_FEATURE: begin
            if (col_last && row_last && ch_last) begin
              waddr_q <= '0;
              pos_q   <= '0;
            end else begin
              waddr_q <= waddr_q + ADDR_W'(1);
              if (win_hit) pos_q <= pos_q + ADDR_W'(1);
            end
            if (!col_last) begin
              col_q <= col_q + CNT_W'(1);
              if (col_hit) ck_q <= ck_q + DIM_W'(cfg.step);
            end else begin
              col_q <= '0;
              ck_q  <= '0;
              if (!row_last) begin
                row_q <= row_q + CNT_W'(1);
                if (row_hit) rk_q <= rk_q + DIM_W'(cfg.step);
              end else begin
                row_q <= '0;
                rk_q  <= '0;
                ch_q  <= ch_last ? '0 : ch_q + CNT_W'(1);
              end
            end
          end
          ACT_GRAD: begin
            if (geom.out_limit != '0) gc_q <= gc_next;
          end
          default: ;
        endcase
      end
    end
  end

  // datapath
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      unique case (action_i)
        ACT_FEATURE: begin
          if (win_hit) begin
            row_base_q <= waddr_q - geom.scan_back;
            pi_q       <= '0;
            pj_q       <= '0;
            first_q    <= 1'b1;
            res_kind_q <= KIND_POOL;
            res_pos_q  <= pos_q;
          end
        end
        ACT_GRAD: grad_val_q <= sample_value_i;
        ACT_READ: begin
          res_kind_q   <= KIND_READ;
          grad_idx_q   <= read_index_i;
          res_value_q  <= '0;
          res_status_q <= range_err ? STAT_RANGE : STAT_OK;
        end
        default: ;
      endcase
    end
    if (state_q == S_SCAN) begin
      iss_idx_q <= frame_raddr;
      if (pj_last) begin
        pj_q       <= '0;
        pi_q       <= pi_q + (WIN_W-1)'(1);
        row_base_q <= row_base_q + ADDR_W'(cfg.width);
      end else begin
        pj_q <= pj_q + (WIN_W-1)'(1);
      end
    end
    // first strict maximum wins
    if (iss_q) begin
      if (first_q || frame_rdata_q > best_q) begin
        best_q    <= frame_rdata_q;
        top_idx_q <= iss_idx_q;
      end
      first_q <= 1'b0;
    end
    if (state_q == S_GRD_W) grad_idx_q <= winner_rdata_q;
    if (state_q == S_RD_WAIT) res_value_q <= grad_rdata_q;
    if (state_q == S_EMIT && out_free) begin
      out_kind_q <= res_kind_q;
      if (res_kind_q == KIND_POOL) begin
        out_value_q  <= pool_value;
        out_widx_q   <= top_idx_q;
        out_pos_q    <= res_pos_q;
        out_status_q <= STAT_OK;
      end else begin
        out_value_q  <= res_value_q;
        out_widx_q   <= '0;
        out_pos_q    <= '0;
        out_status_q <= res_status_q;
      end
    end
  end

  assign out_valid_o       = out_valid_q;
  assign kind_o            = out_kind_q;
  assign result_value_o    = out_value_q;
  assign winner_index_o    = out_widx_q;
  assign output_position_o = out_pos_q;
  assign status_o          = out_status_q;

endmodule

`default_nettype wire

FILE: sv/mpb_checker.sv
// ----------------------------------------------------------------------------
// mpb_checker
// Port-level checks for the max pooling core, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module mpb_checker
  import mpb_pkg::*;
(
  input wire logic                      clk_i,
  input wire logic                      rst_ni,
  input wire logic                      in_valid_i,
  input wire logic                      in_ready_o,
  input wire logic [1:0]                action_i,
  input wire logic signed [VALUE_W-1:0] sample_value_i,
  input wire logic [ADDR_W-1:0]         read_index_i,
  input wire logic                      out_valid_o,
  input wire logic                      out_ready_i,
  input wire logic                      kind_o,
  input wire logic signed [GRAD_W-1:0]  result_value_o,
  input wire logic [ADDR_W-1:0]         winner_index_o,
  input wire logic [ADDR_W-1:0]         output_position_o,
  input wire logic                      status_o,
  input wire logic                      cfg_valid_i,
  input wire logic                      cfg_ready_o,
  input wire logic [CFG_IDX_W-1:0]      cfg_index_i,
  input wire logic [CFG_DATA_W-1:0]     cfg_wdata_i
);

  // stalled result beat holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(result_value_o) &&
    $stable(kind_o) && $stable(winner_index_o) && $stable(output_position_o))
    else $error("result beat changed while stalled");

  a_read_fields: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && kind_o == KIND_READ |-> winner_index_o == '0 && output_position_o == '0)
    else $error("readout beat carries window fields");

  a_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o == STAT_RANGE |-> kind_o == KIND_READ && result_value_o == '0)
    else $error("range error on non-readout or nonzero value");

  a_read_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o && action_i == ACT_READ |=> !in_ready_o)
    else $error("readout did not occupy the core");

  a_cfg_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_valid_i && cfg_ready_o && cfg_index_i <= CFG_STEP && cfg_wdata_i == cfg_wdata_i
    |=> !in_ready_o)
    else $error("input accepted during geometry update");

endmodule

bind max_pool_2d_with_argmax_backprop_core mpb_checker u_mpb_checker (.*);

`default_nettype wire
